FILE: hw/rtl/mflg_pkg.sv
// Shared constants and types for the level-graph max-flow unit.
package mflg_pkg;
   localparam int MaxNodes  = 16;
   localparam int MaxEdges  = 1024;
   localparam int CapBits   = 16;
   localparam int Entries   = 2 * MaxEdges;
   localparam int NodeBits  = $clog2(MaxNodes);
   localparam int EntryBits = $clog2(Entries);
   localparam int PtrBits   = EntryBits + 1;
   localparam int LvlBits   = NodeBits + 1;
   localparam int FlowBits  = 26;
   localparam int DepthBits = NodeBits + 1;

   localparam logic [LvlBits-1:0] NoLevel  = '1;
   localparam logic [PtrBits-1:0] NilEntry = PtrBits'(Entries);
   localparam logic [CapBits-1:0] InfCap   = '1;

   localparam logic OpAddEdge = 1'b0;
   localparam logic OpSolve   = 1'b1;

   typedef struct packed {
      logic [NodeBits-1:0] head;
      logic [CapBits-1:0]  resid;
      logic [PtrBits-1:0]  next;
   } entry_type;
endpackage

FILE: hw/rtl/mflg_if.sv
// Valid/ready channel interfaces for requests, responses and the register port.
interface mflg_req_if import mflg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [3:0]          from_node;
   logic [3:0]          to_node;
   logic [15:0]         capacity;
   modport source (output valid, opcode, from_node, to_node, capacity, input ready);
   modport sink   (input valid, opcode, from_node, to_node, capacity, output ready);
endinterface

interface mflg_rsp_if import mflg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FlowBits-1:0] max_flow;
   logic                edges_overflowed;
   modport source (output valid, max_flow, edges_overflowed, input ready);
   modport sink   (input valid, max_flow, edges_overflowed, output ready);
endinterface

interface mflg_csr_if ();
   logic       valid;
   logic       ready;
   logic [3:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/mflg_edge_ram.sv
// Edge entry memory: head node, residual, next pointer; one port, registered read.
module mflg_edge_ram import mflg_pkg::*; (
   input  logic                 clock,
   input  logic                 we,
   input  logic [EntryBits-1:0] addr,
   input  entry_type            wdata,
   output entry_type            rdata
);
   entry_type mem [Entries];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

FILE: hw/rtl/max_flow_level_graph_unit.sv
// Top level: edge loading and level-graph max-flow solve sequencer.
//
//  channel | dir | transaction
//  req_    | in  | add edge (opcode 0) or solve (opcode 1)
//  rsp_    | out | max_flow and edges_overflowed, one per solve
//  csr_    | in  | node_count write
//
// Add edge: the reverse entry write in S_ADD2 holds req_ready low; a dropped add stays in idle.
// Solve, per phase: setup, dequeue of each node and scan of its entries, a test of the sink;
// then search steps, retreats, and augments: bottleneck pass, then entry and partner updates.
// Emit and clear happen in S_DONE, held while the previous response is still pending.
// Reset is synchronous; the entry RAM needs no clearing, lists are rebuilt.
// req_ready is low whenever the sequencer is not idle.
module max_flow_level_graph_unit import mflg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mflg_req_if.sink  req,
   mflg_rsp_if.source rsp,
   mflg_csr_if.sink  csr
);
   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_ADD2   = 14'b00000000000010,
      S_BINIT  = 14'b00000000000100,
      S_BNODE  = 14'b00000000001000,
      S_BRD    = 14'b00000000010000,
      S_BACT   = 14'b00000000100000,
      S_DFS    = 14'b00000001000000,
      S_DRD    = 14'b00000010000000,
      S_DACT   = 14'b00000100000000,
      S_AMIN   = 14'b00001000000000,
      S_ARD    = 14'b00010000000000,
      S_AUPD   = 14'b00100000000000,
      S_POPRD  = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0]           ncount_ff;
   logic [PtrBits-1:0]   first_ff [MaxNodes];
   logic [PtrBits-1:0]   cur_ff   [MaxNodes];
   logic [LvlBits-1:0]   level_ff [MaxNodes];
   logic [EntryBits-1:0] stack_ff [MaxNodes];
   logic [NodeBits-1:0]  shead_ff [MaxNodes];
   logic [NodeBits-1:0]  queue_ff [MaxNodes];
   logic [PtrBits-1:0]   count_ff;
   logic                 ovf_ff;
   logic [DepthBits-1:0] depth_ff, qh_ff, qt_ff, idx_ff;
   logic [NodeBits-1:0]  u_ff;
   logic [PtrBits-1:0]   e_ff;
   logic [CapBits-1:0]   bott_ff;
   logic [FlowBits:0]    total_ff;
   logic                 rvalid_ff;
   logic [FlowBits-1:0]  rflow_ff;
   logic                 rovf_ff;
   logic [3:0]           pto_ff, pfrom_ff;
   logic                 fwd_ff;
   logic                 side_ff;

   logic                 we;
   logic [EntryBits-1:0] addr;
   entry_type            wdata, rdata;

   mflg_edge_ram u_ram (.clock, .we, .addr, .wdata, .rdata);

   logic [NodeBits-1:0] sink_node;
   logic                sink_ok;
   assign sink_node = NodeBits'(ncount_ff);
   assign sink_ok   = (ncount_ff != 4'd1) && ({1'b0, ncount_ff} < 5'(MaxNodes));

   logic [DepthBits-1:0] depth_dec;
   logic [NodeBits-1:0]  top_u;
   assign depth_dec = depth_ff - 1'b1;
   assign top_u = (depth_ff == '0) ? NodeBits'(1) : shead_ff[depth_dec[NodeBits-1:0]];

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rvalid_ff;
   assign rsp.max_flow = rflow_ff;
   assign rsp.edges_overflowed = rovf_ff;

   logic acc;
   assign acc = req.valid && req.ready;

   // RAM port mux
   always_comb begin
      we = 1'b0;
      addr = e_ff[EntryBits-1:0];
      wdata = rdata;
      if (state_ff == S_IDLE) begin
         addr = count_ff[EntryBits-1:0];
         wdata.head = req.to_node;
         wdata.resid = req.capacity;
         wdata.next = first_ff[req.from_node];
         we = acc && req.opcode == OpAddEdge && !count_ff[EntryBits];
      end else if (state_ff == S_ADD2) begin
         addr = count_ff[EntryBits-1:0] + 1'b1;
         wdata.head = pfrom_ff;
         wdata.resid = '0;
         wdata.next = (pfrom_ff == pto_ff) ? count_ff[PtrBits-1:0] : first_ff[pto_ff];
         we = 1'b1;
      end else if (state_ff == S_ARD || state_ff == S_AUPD) begin
         // side 0: path entry, side 1: its partner
         addr = stack_ff[idx_ff[NodeBits-1:0]] ^ EntryBits'(side_ff);
         if (state_ff == S_AUPD && !fwd_ff) begin
            we = 1'b1;
            wdata.resid = side_ff ? rdata.resid + bott_ff : rdata.resid - bott_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ncount_ff <= 4'd2;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < MaxNodes; i++) begin
            first_ff[i] <= NilEntry;
            level_ff[i] <= NoLevel;
         end
      end else begin
         if (csr.valid) ncount_ff <= csr.data;
         if (rsp.valid && rsp.ready) rvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (acc) begin
               if (req.opcode == OpAddEdge) begin
                  if (count_ff[EntryBits]) ovf_ff <= 1'b1;
                  else begin
                     pfrom_ff <= req.from_node;
                     pto_ff <= req.to_node;
                     first_ff[req.from_node] <= count_ff[PtrBits-1:0];
                     state_ff <= S_ADD2;
                  end
               end else begin
                  total_ff <= '0;
                  state_ff <= sink_ok ? S_BINIT : S_DONE;
               end
            end
            S_ADD2: begin
               first_ff[pto_ff] <= count_ff[PtrBits-1:0] + 1'b1;
               count_ff <= count_ff + PtrBits'(2);
               state_ff <= S_IDLE;
            end
            S_BINIT: begin
               for (int i = 0; i < MaxNodes; i++) begin
                  level_ff[i] <= (i == 1) ? '0 : NoLevel;
                  cur_ff[i] <= first_ff[i];
               end
               queue_ff[0] <= NodeBits'(1);
               qh_ff <= '0;
               qt_ff <= DepthBits'(1);
               idx_ff <= '0;
               state_ff <= S_BNODE;
            end
            S_BNODE: begin
               if (qh_ff == qt_ff) begin
                  depth_ff <= '0;
                  state_ff <= (level_ff[sink_node] != NoLevel) ? S_DFS : S_DONE;
               end else begin
                  u_ff <= queue_ff[qh_ff[NodeBits-1:0]];
                  e_ff <= first_ff[queue_ff[qh_ff[NodeBits-1:0]]];
                  qh_ff <= qh_ff + 1'b1;
                  state_ff <= S_BRD;
               end
            end
            S_BRD: state_ff <= e_ff[PtrBits-1] ? S_BNODE : S_BACT;
            S_BACT: begin
               if (rdata.resid != '0 && level_ff[rdata.head] == NoLevel
                   && qt_ff < DepthBits'(MaxNodes)) begin
                  level_ff[rdata.head] <= level_ff[u_ff] + 1'b1;
                  queue_ff[qt_ff[NodeBits-1:0]] <= rdata.head;
                  qt_ff <= qt_ff + 1'b1;
               end
               e_ff <= rdata.next;
               state_ff <= S_BRD;
            end
            S_DFS: begin
               u_ff <= top_u;
               e_ff <= cur_ff[top_u];
               if (top_u == sink_node) begin
                  bott_ff <= InfCap;
                  idx_ff <= '0;
                  state_ff <= S_AMIN;
               end else if (cur_ff[top_u][PtrBits-1]) begin
                  if (depth_ff == '0) state_ff <= S_BINIT;
                  else begin
                     level_ff[top_u] <= NoLevel;
                     depth_ff <= depth_ff - 1'b1;
                     state_ff <= S_POPRD;
                  end
               end else state_ff <= S_DRD;
            end
            S_POPRD: begin
               // advance parent's current entry
               e_ff <= cur_ff[top_u];
               u_ff <= top_u;
               state_ff <= S_DRD;
               idx_ff <= '1;
            end
            S_DRD: state_ff <= S_DACT;
            S_DACT: begin
               if (idx_ff == '1) begin
                  cur_ff[u_ff] <= rdata.next;
                  idx_ff <= '0;
               end else if (rdata.resid != '0 && level_ff[rdata.head] != NoLevel
                   && level_ff[rdata.head] == level_ff[u_ff] + 1'b1
                   && depth_ff < DepthBits'(MaxNodes)) begin
                  stack_ff[depth_ff[NodeBits-1:0]] <= e_ff[EntryBits-1:0];
                  shead_ff[depth_ff[NodeBits-1:0]] <= rdata.head;
                  depth_ff <= depth_ff + 1'b1;
               end else cur_ff[u_ff] <= rdata.next;
               state_ff <= S_DFS;
            end
            S_AMIN: begin
               fwd_ff <= 1'b1;
               side_ff <= 1'b0;
               state_ff <= S_ARD;
            end
            S_ARD: state_ff <= S_AUPD;
            S_AUPD: begin
               if (fwd_ff) begin
                  // first pass: bottleneck only
                  if (rdata.resid < bott_ff) bott_ff <= rdata.resid;
                  if (idx_ff + 1'b1 == depth_ff) begin
                     idx_ff <= '0;
                     fwd_ff <= 1'b0;
                  end else idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_ARD;
               end else if (!side_ff) begin
                  side_ff <= 1'b1;
                  state_ff <= S_ARD;
               end else begin
                  side_ff <= 1'b0;
                  if (idx_ff + 1'b1 == depth_ff) begin
                     total_ff <= total_ff + (FlowBits+1)'(bott_ff);
                     depth_ff <= '0;
                     state_ff <= S_DFS;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= S_ARD;
                  end
               end
            end
            S_DONE: if (!rvalid_ff) begin
               rvalid_ff <= 1'b1;
               rflow_ff <= total_ff[FlowBits] ? '1 : total_ff[FlowBits-1:0];
               rovf_ff <= ovf_ff;
               ovf_ff <= 1'b0;
               count_ff <= '0;
               for (int i = 0; i < MaxNodes; i++) begin
                  first_ff[i] <= NilEntry;
                  level_ff[i] <= NoLevel;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
